>>> hdl/dbmm_pkg.sv
package dbmm_pkg;

  localparam int PAYLOAD_WIDTH = 64;
  localparam int CHANNEL_COUNT = 4;
  localparam int CH_W          = $clog2(CHANNEL_COUNT);
  localparam int ENTRY_W       = CH_W + 1;
  localparam int CNT_W         = 32;

  // Command codes as they arrive on the command port.
  typedef enum logic [2:0] {
    CMD_WRITE     = 3'd0,
    CMD_READ      = 3'd1,
    CMD_START     = 3'd2,
    CMD_CKSUM_ERR = 3'd3,
    CMD_NODATA    = 3'd4,
    CMD_CNT_RESET = 3'd5
  } command_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_IN_ERR   = 2'd1,
    ST_NO_DATA  = 2'd2
  } status_t;

  localparam logic [CH_W-1:0] CH_PNET     = CH_W'(0);
  localparam logic [CH_W-1:0] CH_PATTERN  = CH_W'(1);
  localparam logic [CH_W-1:0] CH_DATA     = CH_W'(2);
  localparam logic [CH_W-1:0] CH_FIDUCIAL = CH_W'(3);

  localparam logic [CNT_W-1:0] WRAP_LIMIT_RESET = 32'h7FFF_FFFF;

  // The five diagnostic counters of one channel, kept as one memory word.
  typedef struct packed {
    logic [CNT_W-1:0] updates;
    logic [CNT_W-1:0] rollovers;
    logic [CNT_W-1:0] overwrites;
    logic [CNT_W-1:0] no_data_events;
    logic [CNT_W-1:0] checksum_errors;
  } counters_t;

endpackage

>>> hdl/double_buffered_message_mailbox.sv
// Channel       Direction  Signals                                   Transaction when
// command       in         start, busy, command, channel, payload_in start high, busy low
// result        out        done, status, payload_out, *_count        done high (one cycle)
// configuration in         cfg_write, cfg_data                       cfg_write high
//
// Every command has an accept step and an execute step: the accept edge
// issues the reads of the counter and payload memories, the next edge
// applies the read-modify-write and registers the result, and done is high
// in the cycle that follows. busy covers the execute cycle only, so a new
// command can be accepted in the same cycle that done is shown, but none
// while busy. Reset is synchronous: it clears the unread flags, slot indices
// and counter valid bits and sets the wrap limit to its reset value. The
// receiver cannot stall; done is a pulse.
module double_buffered_message_mailbox (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [2:0]                         command,
  input  logic [dbmm_pkg::CH_W-1:0]          channel,
  input  logic [63:0]                        payload_in,
  input  logic                               cfg_write,
  input  logic [dbmm_pkg::CNT_W-1:0]         cfg_data,
  output logic                               done,
  output logic [1:0]                         status,
  output logic [63:0]                        payload_out,
  output logic [dbmm_pkg::CNT_W-1:0]         update_count,
  output logic [dbmm_pkg::CNT_W-1:0]         rollover_count,
  output logic [dbmm_pkg::CNT_W-1:0]         overwrite_count,
  output logic [dbmm_pkg::CNT_W-1:0]         no_data_count,
  output logic [dbmm_pkg::CNT_W-1:0]         checksum_error_count
);

  localparam int NUM_ENTRIES = 2 * dbmm_pkg::CHANNEL_COUNT;

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t state;
  logic   accept;

  // Command held for the execute cycle.
  logic [2:0]                          cmd_q;
  logic [dbmm_pkg::CH_W-1:0]           ch_q;
  logic [dbmm_pkg::PAYLOAD_WIDTH-1:0]  wdata_q;

  logic [dbmm_pkg::CNT_W-1:0] wrap_limit;

  // Small control state lives in flip-flops; the payload words and the
  // counters live in synchronous memories.
  logic [NUM_ENTRIES-1:0]             unread;
  logic [dbmm_pkg::CHANNEL_COUNT-1:0] newest;
  logic [dbmm_pkg::CHANNEL_COUNT-1:0] fiducial;
  logic [dbmm_pkg::CHANNEL_COUNT-1:0] cnt_valid;

  logic [dbmm_pkg::PAYLOAD_WIDTH-1:0] payload_mem [NUM_ENTRIES];
  dbmm_pkg::counters_t                cnt_mem [dbmm_pkg::CHANNEL_COUNT];

  logic [dbmm_pkg::PAYLOAD_WIDTH-1:0] payload_rd;
  dbmm_pkg::counters_t                cnt_rd;

  // Execute-cycle results.
  dbmm_pkg::counters_t                cnt_cur;
  dbmm_pkg::counters_t                cnt_next;
  logic [NUM_ENTRIES-1:0]             unread_next;
  logic [dbmm_pkg::CHANNEL_COUNT-1:0] newest_next;
  logic [dbmm_pkg::CHANNEL_COUNT-1:0] fiducial_next;
  logic [1:0]                         status_next;
  logic [63:0]                        payload_out_next;
  logic                               wr_en;
  logic [dbmm_pkg::ENTRY_W-1:0]       wr_entry;

  assign busy   = (state == EXEC);
  assign accept = start && !busy;

  // Payload memory: written in the execute cycle, read at the accept edge at
  // the fiducial slot of the addressed channel. Only a read command uses the
  // data, and no write can land between the read and the execute cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      payload_mem[wr_entry] <= wdata_q;
    end
    if (accept) begin
      payload_rd <= payload_mem[{channel, fiducial[channel]}];
    end
  end

  // Counter memory: one word per channel, read at accept, written back in
  // the execute cycle.
  always_ff @(posedge clk) begin
    if (state == EXEC) begin
      cnt_mem[ch_q] <= cnt_next;
    end
    if (accept) begin
      cnt_rd <= cnt_mem[channel];
    end
  end

  always_comb begin
    logic                         s;
    logic [dbmm_pkg::ENTRY_W-1:0] e;
    logic                         ps;

    s                = 1'b0;
    e                = {ch_q, fiducial[ch_q]};
    ps               = newest[dbmm_pkg::CH_PATTERN];
    cnt_cur          = cnt_valid[ch_q] ? cnt_rd : '0;
    cnt_next         = cnt_cur;
    unread_next      = unread;
    newest_next      = newest;
    fiducial_next    = fiducial;
    status_next      = dbmm_pkg::ST_OK;
    payload_out_next = '0;
    wr_en            = 1'b0;
    wr_entry         = {ch_q, 1'b0};

    case (cmd_q)
      dbmm_pkg::CMD_WRITE: begin
        // Slot 0 when free (always on PNET), else slot 1 when free, else the
        // slot that is not the fiducial slot.
        if (unread[{ch_q, 1'b0}] && ch_q != dbmm_pkg::CH_PNET) begin
          s = 1'b1;
          if (unread[{ch_q, 1'b1}]) begin
            s = !fiducial[ch_q];
          end
        end
        wr_en             = (state == EXEC);
        wr_entry          = {ch_q, s};
        newest_next[ch_q] = s;
        if (unread[{ch_q, s}]) begin
          cnt_next.overwrites = cnt_cur.overwrites + 1'b1;
        end else begin
          unread_next[{ch_q, s}] = 1'b1;
        end
      end
      dbmm_pkg::CMD_READ: begin
        if (!unread[e]) begin
          cnt_next.no_data_events = cnt_cur.no_data_events + 1'b1;
          status_next             = dbmm_pkg::ST_NO_DATA;
        end else begin
          unread_next[e] = 1'b0;
          if (ch_q == dbmm_pkg::CH_PNET || ch_q == dbmm_pkg::CH_PATTERN) begin
            payload_out_next[dbmm_pkg::PAYLOAD_WIDTH-1:0] = payload_rd;
          end else if (ch_q == dbmm_pkg::CH_DATA) begin
            status_next = dbmm_pkg::ST_IN_ERR;
          end
        end
      end
      dbmm_pkg::CMD_START: begin
        if (cnt_cur.updates < wrap_limit) begin
          cnt_next.updates = cnt_cur.updates + 1'b1;
        end else begin
          cnt_next.updates   = '0;
          cnt_next.rollovers = cnt_cur.rollovers + 1'b1;
        end
        // A fiducial latches the newest pattern slot and drops the other one.
        if (ch_q == dbmm_pkg::CH_FIDUCIAL) begin
          fiducial_next[dbmm_pkg::CH_PATTERN]    = ps;
          unread_next[{dbmm_pkg::CH_PATTERN, !ps}] = 1'b0;
        end
      end
      dbmm_pkg::CMD_CKSUM_ERR: begin
        cnt_next.checksum_errors = cnt_cur.checksum_errors + 1'b1;
      end
      dbmm_pkg::CMD_NODATA: begin
        cnt_next.no_data_events = cnt_cur.no_data_events + 1'b1;
      end
      dbmm_pkg::CMD_CNT_RESET: begin
        cnt_next = '0;
      end
      default: begin
        status_next = dbmm_pkg::ST_IN_ERR;
      end
    endcase
  end

  // Command register has no reset; it is only looked at in the execute cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= command;
      ch_q    <= channel;
      wdata_q <= payload_in[dbmm_pkg::PAYLOAD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      done       <= 1'b0;
      unread     <= '0;
      newest     <= '0;
      fiducial   <= '0;
      cnt_valid  <= '0;
      wrap_limit <= dbmm_pkg::WRAP_LIMIT_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        wrap_limit <= cfg_data;
      end
      case (state)
        IDLE: begin
          if (start) begin
            state <= EXEC;
          end
        end
        EXEC: begin
          state                <= IDLE;
          done                 <= 1'b1;
          unread               <= unread_next;
          newest               <= newest_next;
          fiducial             <= fiducial_next;
          cnt_valid[ch_q]      <= 1'b1;
          status               <= status_next;
          payload_out          <= payload_out_next;
          update_count         <= cnt_next.updates;
          rollover_count       <= cnt_next.rollovers;
          overwrite_count      <= cnt_next.overwrites;
          no_data_count        <= cnt_next.no_data_events;
          checksum_error_count <= cnt_next.checksum_errors;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // A result only ever follows an execute cycle.
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == EXEC))
    else $error("result strobe without an execute cycle");

  // An accepted command is executed in the very next cycle.
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy ##1 done)
    else $error("accepted command did not complete in two cycles");

  // Any status other than ok carries a zero payload.
  a_err_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (done && status != dbmm_pkg::ST_OK) |-> payload_out == '0)
    else $error("payload returned with a failing status");

  // PNET uses slot 0 only, so its second slot never holds an unread message.
  a_pnet_single_slot: assert property (@(posedge clk) disable iff (rst)
    !unread[{dbmm_pkg::CH_PNET, 1'b1}])
    else $error("PNET second slot marked unread");

  // After a fiducial, the pattern channel holds at most its fiducial slot.
  a_fiducial_discard: assert property (@(posedge clk) disable iff (rst)
    (state == EXEC && cmd_q == dbmm_pkg::CMD_START && ch_q == dbmm_pkg::CH_FIDUCIAL)
      |=> !unread[{dbmm_pkg::CH_PATTERN, !fiducial[dbmm_pkg::CH_PATTERN]}])
    else $error("pattern slot survived a fiducial");

endmodule

>>> bench/double_buffered_message_mailbox_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the four-channel double-buffered message mailbox.
// Commands go in through the start/busy handshake. Every accepted command
// returns exactly one result, shown for one cycle under done. A behavioral
// model of the mailbox inside this module predicts each result at the moment
// its command is accepted. The checker compares every result, field by field,
// with the oldest prediction still waiting.
module double_buffered_message_mailbox_test;

  // Codes 6 and 7 are not defined commands. The block must answer them with an
  // input error and leave its state alone.
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam logic [63:0] WORD_ZERO = 64'h0;
  localparam logic [63:0] WORD_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] WORD_ALT_A = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [63:0] WORD_ALT_5 = 64'h5555_5555_5555_5555;

  // A command is accepted, then executed, and done follows the execute cycle.
  // SETTLE_CYCLES is more than enough for the block to go idle.
  localparam int SETTLE_CYCLES = 6;
  // The slowest correct run has roughly 700 commands. Each of them costs at
  // most an idle gap, the work of the command and the drain of its result.
  // That stays far below CYCLE_LIMIT, so this limit only catches a hang.
  localparam int CYCLE_LIMIT = 200000;

  // One result as the block reports it.
  typedef struct packed {
    logic [1:0]                 status;
    logic [63:0]                payload;
    logic [dbmm_pkg::CNT_W-1:0] updates;
    logic [dbmm_pkg::CNT_W-1:0] rollovers;
    logic [dbmm_pkg::CNT_W-1:0] overwrites;
    logic [dbmm_pkg::CNT_W-1:0] no_data_events;
    logic [dbmm_pkg::CNT_W-1:0] checksum_errors;
  } mailbox_reply_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic [2:0]                 command = dbmm_pkg::CMD_WRITE;
  logic [dbmm_pkg::CH_W-1:0]  channel = dbmm_pkg::CH_PNET;
  logic [63:0]                payload_in = '0;
  logic                       cfg_write = 1'b0;
  logic [dbmm_pkg::CNT_W-1:0] cfg_data = '0;

  logic                       busy;
  logic                       done;
  logic [1:0]                 status;
  logic [63:0]                payload_out;
  logic [dbmm_pkg::CNT_W-1:0] update_count;
  logic [dbmm_pkg::CNT_W-1:0] rollover_count;
  logic [dbmm_pkg::CNT_W-1:0] overwrite_count;
  logic [dbmm_pkg::CNT_W-1:0] no_data_count;
  logic [dbmm_pkg::CNT_W-1:0] checksum_error_count;

  // Mailbox model state. Slot s of channel c is entry {c, s}.
  logic [63:0]                slot_word   [dbmm_pkg::CHANNEL_COUNT*2];
  logic                       slot_unread [dbmm_pkg::CHANNEL_COUNT*2];
  logic                       newest_of   [dbmm_pkg::CHANNEL_COUNT];
  logic                       fiducial_of [dbmm_pkg::CHANNEL_COUNT];
  dbmm_pkg::counters_t        tallies     [dbmm_pkg::CHANNEL_COUNT];
  logic [dbmm_pkg::CNT_W-1:0] wrap_limit;

  // Predicted results, oldest first, waiting for the block to report them.
  mailbox_reply_t pending_replies [$];

  int error_count = 0;
  int items_sent = 0;
  int cycle_count = 0;
  // Chance, in percent, that the sender idles for a while before a command.
  int sender_idle_pct = 0;

  double_buffered_message_mailbox DUT (
    .clk                  (clk),
    .rst                  (rst),
    .start                (start),
    .busy                 (busy),
    .command              (command),
    .channel              (channel),
    .payload_in           (payload_in),
    .cfg_write            (cfg_write),
    .cfg_data             (cfg_data),
    .done                 (done),
    .status               (status),
    .payload_out          (payload_out),
    .update_count         (update_count),
    .rollover_count       (rollover_count),
    .overwrite_count      (overwrite_count),
    .no_data_count        (no_data_count),
    .checksum_error_count (checksum_error_count)
  );

  always #6 clk = ~clk;

  // Bring the model to its state after reset. Slot words are never read
  // before they are written, so they are cleared only to keep them defined.
  task automatic mailbox_model_reset();
    for (int i = 0; i < dbmm_pkg::CHANNEL_COUNT*2; i++) begin
      slot_word[i] = '0;
      slot_unread[i] = 1'b0;
    end
    for (int c = 0; c < dbmm_pkg::CHANNEL_COUNT; c++) begin
      newest_of[c] = 1'b0;
      fiducial_of[c] = 1'b0;
      tallies[c] = '0;
    end
    wrap_limit = dbmm_pkg::WRAP_LIMIT_RESET;
  endtask

  // Apply one command to the model and return the result it produces. The
  // result reports the channel's counters after the command has taken effect.
  function automatic mailbox_reply_t mailbox_apply(input logic [2:0] cmd,
                                                   input logic [dbmm_pkg::CH_W-1:0] ch,
                                                   input logic [63:0] word);
    mailbox_reply_t reply;
    logic sel;
    reply = '0;
    reply.status = dbmm_pkg::ST_OK;
    case (cmd)
      dbmm_pkg::CMD_WRITE: begin
        // Slot 0 is used when it is free, and PNET always uses slot 0. Slot 1
        // is used next. When both slots are full, the write replaces the slot
        // that is not the fiducial one.
        sel = 1'b0;
        if (slot_unread[{ch, 1'b0}] && ch != dbmm_pkg::CH_PNET) begin
          sel = 1'b1;
          if (slot_unread[{ch, 1'b1}]) sel = ~fiducial_of[ch];
        end
        slot_word[{ch, sel}] = word;
        newest_of[ch] = sel;
        if (slot_unread[{ch, sel}]) tallies[ch].overwrites = tallies[ch].overwrites + 1;
        else slot_unread[{ch, sel}] = 1'b1;
      end
      dbmm_pkg::CMD_READ: begin
        sel = fiducial_of[ch];
        if (!slot_unread[{ch, sel}]) begin
          reply.status = dbmm_pkg::ST_NO_DATA;
          tallies[ch].no_data_events = tallies[ch].no_data_events + 1;
        end else begin
          // Only PNET and PATTERN hand back the word. A DATA read is an input
          // error, but it still consumes the message.
          if (ch == dbmm_pkg::CH_PNET || ch == dbmm_pkg::CH_PATTERN)
            reply.payload = slot_word[{ch, sel}];
          else if (ch == dbmm_pkg::CH_DATA) reply.status = dbmm_pkg::ST_IN_ERR;
          slot_unread[{ch, sel}] = 1'b0;
        end
      end
      dbmm_pkg::CMD_START: begin
        if (tallies[ch].updates < wrap_limit) begin
          tallies[ch].updates = tallies[ch].updates + 1;
        end else begin
          tallies[ch].updates = '0;
          tallies[ch].rollovers = tallies[ch].rollovers + 1;
        end
        // The fiducial start latches PATTERN's newest slot as its fiducial
        // slot and throws away the other one.
        if (ch == dbmm_pkg::CH_FIDUCIAL) begin
          sel = newest_of[dbmm_pkg::CH_PATTERN];
          fiducial_of[dbmm_pkg::CH_PATTERN] = sel;
          slot_unread[{dbmm_pkg::CH_PATTERN, ~sel}] = 1'b0;
        end
      end
      dbmm_pkg::CMD_CKSUM_ERR: begin
        tallies[ch].checksum_errors = tallies[ch].checksum_errors + 1;
      end
      dbmm_pkg::CMD_NODATA: begin
        tallies[ch].no_data_events = tallies[ch].no_data_events + 1;
      end
      dbmm_pkg::CMD_CNT_RESET: begin
        tallies[ch] = '0;
      end
      default: begin
        reply.status = dbmm_pkg::ST_IN_ERR;
      end
    endcase
    reply.updates = tallies[ch].updates;
    reply.rollovers = tallies[ch].rollovers;
    reply.overwrites = tallies[ch].overwrites;
    reply.no_data_events = tallies[ch].no_data_events;
    reply.checksum_errors = tallies[ch].checksum_errors;
    return reply;
  endfunction

  // Random message word. The extremes come up often enough that reads of
  // all-zero and all-one words stay common.
  function automatic logic [63:0] random_word();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return WORD_ZERO;
    if (pick == 1) return WORD_ONES;
    return {$urandom, $urandom};
  endfunction

  // Random channel number.
  function automatic logic [dbmm_pkg::CH_W-1:0] random_channel();
    logic [31:0] pick;
    pick = $urandom_range(dbmm_pkg::CHANNEL_COUNT - 1);
    return pick[dbmm_pkg::CH_W-1:0];
  endfunction

  // Present one command and hold it until the block accepts it: that happens
  // at a rising edge where start is high and busy is low. Right after the edge,
  // busy still shows its value from before the edge. start stays high after
  // acceptance, so back-to-back commands never lower and raise it in one step.
  task automatic send_command(input logic [2:0] cmd,
                              input logic [dbmm_pkg::CH_W-1:0] ch,
                              input logic [63:0] word);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    channel <= ch;
    payload_in <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_replies.push_back(mailbox_apply(cmd, ch, word));
    items_sent++;
  endtask

  // Stop sending and let every outstanding result come back. Then give the
  // block a few more cycles so that it is surely idle.
  task automatic wait_until_quiet();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the update wrap limit. This happens only while the block is idle.
  task automatic set_wrap_limit(input logic [dbmm_pkg::CNT_W-1:0] limit);
    wait_until_quiet();
    cfg_write <= 1'b1;
    cfg_data <= limit;
    @(posedge clk);
    cfg_write <= 1'b0;
    wrap_limit = limit;
  endtask

  // Short hand-picked sequence. It covers the extreme payloads, every command,
  // PNET's single slot, the overwrite of a full PATTERN buffer, the fiducial
  // latch, no-data reads, a DATA read and the two unused command codes.
  task automatic test_directed_cases();
    sender_idle_pct = 0;
    send_command(dbmm_pkg::CMD_READ, dbmm_pkg::CH_PATTERN, WORD_ZERO);
    send_command(dbmm_pkg::CMD_WRITE, dbmm_pkg::CH_PNET, WORD_ZERO);
    send_command(dbmm_pkg::CMD_WRITE, dbmm_pkg::CH_PNET, WORD_ONES);
    send_command(dbmm_pkg::CMD_READ, dbmm_pkg::CH_PNET, WORD_ZERO);
    send_command(dbmm_pkg::CMD_WRITE, dbmm_pkg::CH_PATTERN, WORD_ALT_A);
    send_command(dbmm_pkg::CMD_WRITE, dbmm_pkg::CH_PATTERN, WORD_ALT_5);
    send_command(dbmm_pkg::CMD_WRITE, dbmm_pkg::CH_PATTERN, WORD_ONES);
    send_command(dbmm_pkg::CMD_START, dbmm_pkg::CH_FIDUCIAL, WORD_ZERO);
    send_command(dbmm_pkg::CMD_READ, dbmm_pkg::CH_PATTERN, WORD_ONES);
    send_command(dbmm_pkg::CMD_READ, dbmm_pkg::CH_PATTERN, WORD_ONES);
    send_command(dbmm_pkg::CMD_WRITE, dbmm_pkg::CH_DATA, WORD_ALT_5);
    send_command(dbmm_pkg::CMD_READ, dbmm_pkg::CH_DATA, WORD_ZERO);
    send_command(dbmm_pkg::CMD_WRITE, dbmm_pkg::CH_FIDUCIAL, WORD_ALT_A);
    send_command(dbmm_pkg::CMD_READ, dbmm_pkg::CH_FIDUCIAL, WORD_ZERO);
    send_command(dbmm_pkg::CMD_CKSUM_ERR, dbmm_pkg::CH_DATA, WORD_ZERO);
    send_command(dbmm_pkg::CMD_NODATA, dbmm_pkg::CH_FIDUCIAL, WORD_ZERO);
    send_command(dbmm_pkg::CMD_START, dbmm_pkg::CH_PNET, WORD_ZERO);
    send_command(dbmm_pkg::CMD_CNT_RESET, dbmm_pkg::CH_FIDUCIAL, WORD_ZERO);
    send_command(CMD_SPARE_6, dbmm_pkg::CH_PATTERN, WORD_ONES);
    send_command(CMD_SPARE_7, dbmm_pkg::CH_DATA, WORD_ONES);
  endtask

  // Exercise the update wrap at both ends of the limit's range and at a few
  // small values. A limit of zero makes every start a rollover.
  task automatic test_wrap_limits();
    logic [dbmm_pkg::CNT_W-1:0] limits [4];
    limits[0] = '0;
    limits[1] = 32'd1;
    limits[2] = 32'd3;
    limits[3] = 32'hFFFF_FFFF;
    foreach (limits[i]) begin
      set_wrap_limit(limits[i]);
      repeat (5) send_command(dbmm_pkg::CMD_START, random_channel(), random_word());
      send_command(dbmm_pkg::CMD_START, dbmm_pkg::CH_FIDUCIAL, random_word());
    end
  endtask

  // One well-formed message cycle with random content. PATTERN, and at times PNET, DATA
  // and FIDUCIAL, are written, the fiducial start latches PATTERN, and then the consumer
  // reads. Sometimes a read is repeated, so no-data answers keep coming up.
  task automatic send_frame();
    int burst;
    if ($urandom_range(1))
      send_command(dbmm_pkg::CMD_WRITE, dbmm_pkg::CH_PNET, random_word());
    burst = $urandom_range(1, 3);
    repeat (burst) send_command(dbmm_pkg::CMD_WRITE, dbmm_pkg::CH_PATTERN, random_word());
    if ($urandom_range(3) == 0)
      send_command(dbmm_pkg::CMD_WRITE, dbmm_pkg::CH_DATA, random_word());
    if ($urandom_range(3) == 0)
      send_command(dbmm_pkg::CMD_WRITE, dbmm_pkg::CH_FIDUCIAL, random_word());
    send_command(dbmm_pkg::CMD_START, dbmm_pkg::CH_FIDUCIAL, random_word());
    if ($urandom_range(3) != 0)
      send_command(dbmm_pkg::CMD_READ, dbmm_pkg::CH_PATTERN, random_word());
    if ($urandom_range(1))
      send_command(dbmm_pkg::CMD_READ, dbmm_pkg::CH_PNET, random_word());
    if ($urandom_range(4) == 0)
      send_command(dbmm_pkg::CMD_READ, random_channel(), random_word());
    if ($urandom_range(5) == 0)
      send_command(dbmm_pkg::CMD_START, random_channel(), random_word());
  endtask

  // Random traffic in phases. Each phase has its own sender idling and its
  // own wrap limit. Most of the traffic is well-formed frames, and the rest is
  // loose commands on random channels. Counter resets stay rare, so the
  // counters get a chance to grow.
  task automatic test_random_traffic();
    int idle_plan [4];
    logic [dbmm_pkg::CNT_W-1:0] limit_plan [4];
    int target;
    int pick;
    logic [2:0] cmd;
    idle_plan[0] = 0;
    idle_plan[1] = 51;
    idle_plan[2] = 0;
    idle_plan[3] = 18;
    limit_plan[0] = 32'd2;
    limit_plan[1] = $urandom;
    limit_plan[2] = dbmm_pkg::WRAP_LIMIT_RESET;
    limit_plan[3] = 32'd5;
    foreach (idle_plan[p]) begin
      set_wrap_limit(limit_plan[p]);
      sender_idle_pct = idle_plan[p];
      target = items_sent + 150;
      while (items_sent < target) begin
        if ($urandom_range(99) < 70) begin
          send_frame();
        end else begin
          pick = $urandom_range(99);
          if (pick < 25) cmd = dbmm_pkg::CMD_WRITE;
          else if (pick < 50) cmd = dbmm_pkg::CMD_READ;
          else if (pick < 70) cmd = dbmm_pkg::CMD_START;
          else if (pick < 80) cmd = dbmm_pkg::CMD_CKSUM_ERR;
          else if (pick < 90) cmd = dbmm_pkg::CMD_NODATA;
          else if (pick < 96) cmd = dbmm_pkg::CMD_CNT_RESET;
          else if (pick < 98) cmd = CMD_SPARE_6;
          else cmd = CMD_SPARE_7;
          send_command(cmd, random_channel(), random_word());
        end
      end
    end
  endtask

  // Report one field that differs from its prediction.
  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      error_count++;
    end
  endtask

  // Result checker. done lasts exactly one cycle, and the result is taken at
  // the edge that ends that cycle. The values sampled here are the ones from
  // before the edge.
  always @(posedge clk) begin
    mailbox_reply_t want;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: result with no transaction outstanding: expected none, actual status %0d",
                 $time, status);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        compare_field("status", 64'(want.status), 64'(status));
        compare_field("payload_out", want.payload, payload_out);
        compare_field("update_count", 64'(want.updates), 64'(update_count));
        compare_field("rollover_count", 64'(want.rollovers), 64'(rollover_count));
        compare_field("overwrite_count", 64'(want.overwrites), 64'(overwrite_count));
        compare_field("no_data_count", 64'(want.no_data_events), 64'(no_data_count));
        compare_field("checksum_error_count", 64'(want.checksum_errors),
                      64'(checksum_error_count));
      end
    end
  end

  // Watchdog. A hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("double_buffered_message_mailbox_test: done, errors");
      $finish;
    end
  end

  // Reset is held at the start and never asserted again. The wrap limit starts
  // at its reset value. It is first written once the directed sequence is over.
  initial begin
    mailbox_model_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_wrap_limits();
    test_random_traffic();
    wait_until_quiet();
    if (error_count == 0) begin
      $display("double_buffered_message_mailbox_test: done, clean");
    end else begin
      $display("double_buffered_message_mailbox_test: done, errors");
    end
    $finish;
  end

endmodule
